FILE: hw/rtl/redshift_doppler_shade_assert.svh
// Assertion macros used by the checker of the Doppler shading block.
`ifndef REDSHIFT_DOPPLER_SHADE_ASSERT_SVH
`define REDSHIFT_DOPPLER_SHADE_ASSERT_SVH

// Checked at every rising clock edge except while reset is applied.
`define RDS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define RDS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/rdsh_pkg.sv
// Types and constants of the Doppler and gravitational shading block.
package rdsh_pkg;

    localparam int FRAC = 16;
    localparam int ONE = 1 << FRAC;
    localparam int THR = (ONE + 500) / 1000;
    localparam longint THR_SQ = longint'(THR) * longint'(THR);
    localparam int B999 = (999 * ONE) / 1000;
    localparam int T_MIN = (ONE + 50) / 100;

    typedef enum logic [2:0] {
        CFG_CAMERA_X       = 3'd0,
        CFG_CAMERA_Y       = 3'd1,
        CFG_CAMERA_Z       = 3'd2,
        CFG_HORIZON_RADIUS = 3'd3,
        CFG_LIGHT_SPEED    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic        [7:0]  base_red;
        logic        [7:0]  base_green;
        logic        [7:0]  base_blue;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic        [30:0] hole_distance;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } out_item_t;

    // Values that ride along with an item through the arithmetic units.
    typedef struct packed {
        logic [7:0]  base_red;
        logic [7:0]  base_green;
        logic [7:0]  base_blue;
        logic [30:0] hole_dist;
        logic [62:0] dot_mag;
        logic        neg;
        logic        flag;
        logic [21:0] dop;
        logic        gok;
        logic [21:0] t;
        logic        rsat;
        logic [16:0] rq;
        logic        ksat;
    } side_t;

endpackage

FILE: hw/rtl/rdsh_in_if.sv
// Particle input channel of the shading block.
interface rdsh_in_if;
    logic               valid;
    logic               ready;
    rdsh_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rdsh_out_if.sv
// Color result channel of the shading block.
interface rdsh_out_if;
    logic                valid;
    logic                ready;
    rdsh_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rdsh_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module rdsh_div #(
    parameter int NW = 8,
    parameter int DW = 8,
    parameter int QW = 8,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_vld,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_vld,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] side_out
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic          vld_reg  [QW];
    logic [NW-1:0] rem_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        localparam int SH = QW - 1 - i;
        logic          vld_in;
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [SW-1:0] side_s;
        logic [CW-1:0] trial;
        logic          take;

        if (i == 0) begin : g_first
            assign vld_in = in_vld;
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
            assign side_s = side_in;
        end else begin : g_next
            assign vld_in = vld_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign side_s = side_reg[i-1];
        end

        assign trial = CW'(den_in) << SH;
        assign take  = CW'(rem_in) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= take ? NW'(CW'(rem_in) - trial) : rem_in;
                den_reg[i]  <= den_in;
                quo_reg[i]  <= quo_in | (QW'(take) << SH);
                side_reg[i] <= side_s;
            end
        end
    end

    assign out_vld  = vld_reg[QW-1];
    assign quo      = quo_reg[QW-1];
    assign side_out = side_reg[QW-1];

endmodule

FILE: hw/rtl/rdsh_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module rdsh_sqrt #(
    parameter int IW = 8,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  logic [IW-1:0]   radicand,
    input  logic [SW-1:0]   side_in,
    output logic            out_vld,
    output logic [IW/2-1:0] root,
    output logic [SW-1:0]   side_out
);

    localparam int RW = IW / 2;

    logic          vld_reg  [RW];
    logic [IW-1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [SW-1:0] side_reg [RW];

    for (genvar i = 0; i < RW; i++) begin : g_stage
        localparam int J = RW - 1 - i;
        logic          vld_in;
        logic [IW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [SW-1:0] side_s;
        logic [IW:0]   trial;
        logic          take;

        if (i == 0) begin : g_first
            assign vld_in  = in_vld;
            assign rem_in  = radicand;
            assign root_in = '0;
            assign side_s  = side_in;
        end else begin : g_next
            assign vld_in  = vld_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign side_s  = side_reg[i-1];
        end

        assign trial = ((IW+1)'(root_in) << (J + 1)) | ((IW+1)'(1) << (2 * J));
        assign take  = (IW+1)'(rem_in) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= take ? IW'((IW+1)'(rem_in) - trial) : rem_in;
                root_reg[i] <= root_in | (RW'(take) << J);
                side_reg[i] <= side_s;
            end
        end
    end

    assign out_vld  = vld_reg[RW-1];
    assign root     = root_reg[RW-1];
    assign side_out = side_reg[RW-1];

endmodule

FILE: hw/rtl/redshift_doppler_shade.sv
// Doppler and gravitational false-color shading of particles, one color per particle.
// The block accepts one particle per clock when not stalled; the pipeline is a chain
// of bit-per-stage dividers and square roots (radial length, radial speed, beta,
// Doppler ratio and root, gravity quotient and root, ramp red channel, brightening
// factor) plus thirteen arithmetic stages. The whole pipeline advances together and
// holds while a finished color waits to be taken. The user must write configuration
// through the plain write port while no item is in flight; the block does not check.
module redshift_doppler_shade (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    rdsh_in_if.sink           particle,
    rdsh_out_if.source        shade
);

    localparam int SW = $bits(rdsh_pkg::side_t);

    logic signed [31:0] cam_reg [3];
    logic [30:0]        rs_reg;
    logic [30:0]        light_reg;
    logic               en;

    logic                  out_vld_reg;
    rdsh_pkg::out_item_t   out_reg;

    assign en             = !out_vld_reg || shade.ready;
    assign particle.ready = en;
    assign shade.valid    = out_vld_reg;
    assign shade.data     = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_reg[0] <= 32'sd0;
            cam_reg[1] <= 32'sd19660800;
            cam_reg[2] <= 32'sd0;
            rs_reg     <= 31'd65536;
            light_reg  <= 31'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rdsh_pkg::CFG_CAMERA_X:       cam_reg[0] <= cfg_data;
                rdsh_pkg::CFG_CAMERA_Y:       cam_reg[1] <= cfg_data;
                rdsh_pkg::CFG_CAMERA_Z:       cam_reg[2] <= cfg_data;
                rdsh_pkg::CFG_HORIZON_RADIUS: rs_reg     <= cfg_data[30:0];
                rdsh_pkg::CFG_LIGHT_SPEED:    light_reg  <= cfg_data[30:0];
                default:                      ;
            endcase
        end
    end

    // Stage A: camera vector.
    logic               a_vld_reg;
    logic signed [32:0] a_e_reg [3];
    logic signed [31:0] a_v_reg [3];
    rdsh_pkg::side_t    a_side_reg;
    logic signed [31:0] pos [3];
    logic signed [31:0] vel [3];
    rdsh_pkg::side_t    a_side_next;

    assign pos[0] = particle.data.pos_x;
    assign pos[1] = particle.data.pos_y;
    assign pos[2] = particle.data.pos_z;
    assign vel[0] = particle.data.vel_x;
    assign vel[1] = particle.data.vel_y;
    assign vel[2] = particle.data.vel_z;

    always_comb
    begin
        a_side_next            = '0;
        a_side_next.base_red   = particle.data.base_red;
        a_side_next.base_green = particle.data.base_green;
        a_side_next.base_blue  = particle.data.base_blue;
        a_side_next.hole_dist  = particle.data.hole_distance;
    end

    // Stage B: scale the vector below the component limit.
    logic               b_vld_reg;
    logic [29:0]        b_m_reg [3];
    logic signed [30:0] b_es_reg [3];
    logic signed [31:0] b_v_reg [3];
    logic               b_scaled_reg;
    rdsh_pkg::side_t    b_side_reg;
    logic [32:0]        mag [3];
    logic [32:0]        mag_or;
    logic [1:0]         sh;
    logic [29:0]        b_m_next [3];
    logic signed [30:0] b_es_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = a_e_reg[i][32] ? 33'(-a_e_reg[i]) : 33'(a_e_reg[i]);
        end
        mag_or = mag[0] | mag[1] | mag[2];
        if (mag_or[32])
        begin
            sh = 2'd3;
        end
        else if (mag_or[31])
        begin
            sh = 2'd2;
        end
        else if (mag_or[30])
        begin
            sh = 2'd1;
        end
        else
        begin
            sh = 2'd0;
        end
        for (int i = 0; i < 3; i++)
        begin
            b_m_next[i]  = 30'(mag[i] >> sh);
            b_es_next[i] = a_e_reg[i][32] ? -$signed({1'b0, b_m_next[i]})
                                          : $signed({1'b0, b_m_next[i]});
        end
    end

    // Stage C: squares and velocity products.
    logic               c_vld_reg;
    logic [59:0]        c_sq_reg [3];
    logic signed [62:0] c_ve_reg [3];
    logic               c_scaled_reg;
    rdsh_pkg::side_t    c_side_reg;

    // Stage D: squared length, dot product and the length test.
    logic               d_vld_reg;
    logic [61:0]        d_sum_reg;
    rdsh_pkg::side_t    d_side_reg;
    logic [61:0]        d_sum_next;
    logic signed [63:0] dot;
    rdsh_pkg::side_t    d_side_next;

    always_comb
    begin
        d_sum_next = 62'(c_sq_reg[0]) + 62'(c_sq_reg[1]) + 62'(c_sq_reg[2]);
        dot = 64'(c_ve_reg[0]) + 64'(c_ve_reg[1]) + 64'(c_ve_reg[2]);
        d_side_next         = c_side_reg;
        d_side_next.dot_mag = dot[63] ? 63'(-dot) : 63'(dot);
        d_side_next.neg     = dot[63];
        d_side_next.flag    = c_scaled_reg || (64'(d_sum_next) > 64'(rdsh_pkg::THR_SQ));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= particle.valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_e_reg[i]  <= 33'(cam_reg[i]) - 33'(pos[i]);
                a_v_reg[i]  <= vel[i];
                b_m_reg[i]  <= b_m_next[i];
                b_es_reg[i] <= b_es_next[i];
                b_v_reg[i]  <= a_v_reg[i];
                c_sq_reg[i] <= b_m_reg[i] * b_m_reg[i];
                c_ve_reg[i] <= b_v_reg[i] * b_es_reg[i];
            end
            a_side_reg   <= a_side_next;
            b_scaled_reg <= sh != 2'd0;
            b_side_reg   <= a_side_reg;
            c_scaled_reg <= b_scaled_reg;
            c_side_reg   <= b_side_reg;
            d_sum_reg    <= d_sum_next;
            d_side_reg   <= d_side_next;
        end
    end

    // Length of the camera vector.
    logic            s1_vld;
    logic [30:0]     s1_root;
    rdsh_pkg::side_t s1_side;

    rdsh_sqrt #(.IW(62), .SW(SW)) u_len_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(d_vld_reg),
        .radicand(d_sum_reg), .side_in(d_side_reg),
        .out_vld(s1_vld), .root(s1_root), .side_out(s1_side)
    );

    // Radial speed magnitude.
    logic            q1_vld;
    logic [33:0]     q1;
    rdsh_pkg::side_t q1_side;

    rdsh_div #(.NW(63), .DW(31), .QW(34), .SW(SW)) u_speed_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(s1_vld),
        .num(s1_side.dot_mag), .den((s1_root == 31'd0) ? 31'd1 : s1_root),
        .side_in(s1_side),
        .out_vld(q1_vld), .quo(q1), .side_out(q1_side)
    );

    // Stage E: beta dividend, saturated where the quotient would overflow its 17 bits.
    logic            e_vld_reg;
    logic [49:0]     e_num_reg;
    logic [30:0]     e_den_reg;
    rdsh_pkg::side_t e_side_reg;
    logic [30:0]     light_eff;
    logic [49:0]     beta_num;
    logic [49:0]     beta_lim;

    always_comb
    begin
        light_eff = (light_reg == 31'd0) ? 31'd1 : light_reg;
        beta_num  = {q1, 16'd0};
        beta_lim  = 50'({light_eff, 17'd0});
    end

    logic            q2_vld;
    logic [16:0]     q2;
    rdsh_pkg::side_t q2_side;

    rdsh_div #(.NW(50), .DW(31), .QW(17), .SW(SW)) u_beta_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(e_vld_reg),
        .num(e_num_reg), .den(e_den_reg), .side_in(e_side_reg),
        .out_vld(q2_vld), .quo(q2), .side_out(q2_side)
    );

    // Stage F: clamp beta, zero it when the length test fails, and form the Doppler ratio operands.
    logic            f_vld_reg;
    logic [33:0]     f_num_reg;
    logic [17:0]     f_den_reg;
    rdsh_pkg::side_t f_side_reg;
    logic [16:0]     beta_mag;
    logic [17:0]     ratio_hi;
    logic [17:0]     ratio_lo;

    always_comb
    begin
        beta_mag = (q2 > 17'(rdsh_pkg::B999)) ? 17'(rdsh_pkg::B999) : q2;
        if (!q2_side.flag)
        begin
            beta_mag = '0;
        end
        ratio_hi = 18'(rdsh_pkg::ONE) + 18'(beta_mag);
        ratio_lo = 18'(rdsh_pkg::ONE) - 18'(beta_mag);
    end

    logic            q3_vld;
    logic [27:0]     q3;
    rdsh_pkg::side_t q3_side;

    rdsh_div #(.NW(34), .DW(18), .QW(28), .SW(SW)) u_ratio_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(f_vld_reg),
        .num(f_num_reg), .den(f_den_reg), .side_in(f_side_reg),
        .out_vld(q3_vld), .quo(q3), .side_out(q3_side)
    );

    logic            s2_vld;
    logic [21:0]     s2_root;
    rdsh_pkg::side_t s2_side;

    rdsh_sqrt #(.IW(44), .SW(SW)) u_dop_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(q3_vld),
        .radicand({q3, 16'd0}), .side_in(q3_side),
        .out_vld(s2_vld), .root(s2_root), .side_out(s2_side)
    );

    // Stage G: gravity operands.
    logic            g_vld_reg;
    logic [46:0]     g_num_reg;
    logic [30:0]     g_den_reg;
    rdsh_pkg::side_t g_side_reg;
    rdsh_pkg::side_t g_side_next;

    always_comb
    begin
        g_side_next     = s2_side;
        g_side_next.dop = s2_root;
        g_side_next.gok = (38'(s2_side.hole_dist) * 38'd100) > (38'(rs_reg) * 38'd101);
    end

    logic            q4_vld;
    logic [15:0]     q4;
    rdsh_pkg::side_t q4_side;

    rdsh_div #(.NW(47), .DW(31), .QW(16), .SW(SW)) u_grav_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(g_vld_reg),
        .num(g_num_reg), .den(g_den_reg), .side_in(g_side_reg),
        .out_vld(q4_vld), .quo(q4), .side_out(q4_side)
    );

    logic            s3_vld;
    logic [15:0]     s3_root;
    rdsh_pkg::side_t s3_side;

    rdsh_sqrt #(.IW(32), .SW(SW)) u_grav_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(q4_vld),
        .radicand({q4, 16'd0}), .side_in(q4_side),
        .out_vld(s3_vld), .root(s3_root), .side_out(s3_side)
    );

    // Stage H: Doppler times gravity.
    logic            h_vld_reg;
    logic [37:0]     h_prod_reg;
    rdsh_pkg::side_t h_side_reg;
    logic [15:0]     grav;

    assign grav = s3_side.gok ? s3_root : 16'd0;

    // Stage I: ramp position with its floor.
    logic            i_vld_reg;
    rdsh_pkg::side_t i_side_reg;
    rdsh_pkg::side_t i_side_next;
    logic [21:0]     t_raw;

    always_comb
    begin
        t_raw            = h_prod_reg[37:16];
        i_side_next      = h_side_reg;
        i_side_next.t    = (t_raw < 22'(rdsh_pkg::T_MIN)) ? 22'(rdsh_pkg::T_MIN) : t_raw;
        i_side_next.rsat = i_side_next.t <= 22'(2 * rdsh_pkg::ONE);
    end

    logic            q6_vld;
    logic [15:0]     q6;
    rdsh_pkg::side_t q6_side;

    rdsh_div #(.NW(34), .DW(22), .QW(16), .SW(SW)) u_red_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(i_vld_reg),
        .num(34'd1 << (2 * rdsh_pkg::FRAC + 1)), .den(i_side_reg.t),
        .side_in(i_side_reg),
        .out_vld(q6_vld), .quo(q6), .side_out(q6_side)
    );

    // Stage J: red ramp value and brightening operands.
    logic            j_vld_reg;
    logic [48:0]     j_num_reg;
    logic [30:0]     j_den_reg;
    rdsh_pkg::side_t j_side_reg;
    rdsh_pkg::side_t j_side_next;
    logic [30:0]     dmax;
    logic [32:0]     rs3;

    always_comb
    begin
        dmax = (rs_reg > q6_side.hole_dist) ? rs_reg : q6_side.hole_dist;
        rs3  = 33'(rs_reg) * 33'd3;
        j_side_next      = q6_side;
        j_side_next.rq   = q6_side.rsat ? 17'(rdsh_pkg::ONE) : 17'(q6);
        j_side_next.ksat = (dmax == 31'd0) || (rs3 >= 33'(dmax));
    end

    logic            q5_vld;
    logic [15:0]     q5;
    rdsh_pkg::side_t q5_side;

    rdsh_div #(.NW(49), .DW(31), .QW(16), .SW(SW)) u_bright_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(j_vld_reg),
        .num(j_num_reg), .den(j_den_reg), .side_in(j_side_reg),
        .out_vld(q5_vld), .quo(q5), .side_out(q5_side)
    );

    // Stage K: ramp colors and brightening factor.
    logic        k_vld_reg;
    logic [7:0]  k_ramp_reg [3];
    logic [7:0]  k_base_reg [3];
    logic [14:0] k_k_reg;
    logic [16:0] k0;
    logic [33:0] k_scaled;
    logic [21:0] tdev;
    logic [22:0] tdev2;
    logic [16:0] gq;
    logic [16:0] bq;
    logic [22:0] bdev;
    logic [24:0] ramp_full [3];

    always_comb
    begin
        k0       = q5_side.ksat ? 17'(rdsh_pkg::ONE) : 17'(q5);
        k_scaled = (34'(k0) << 1) * 34'd52429;
        tdev     = (q5_side.t >= 22'(rdsh_pkg::ONE)) ? q5_side.t - 22'(rdsh_pkg::ONE)
                                                     : 22'(rdsh_pkg::ONE) - q5_side.t;
        tdev2    = 23'(tdev) << 1;
        gq       = (tdev2 >= 23'(rdsh_pkg::ONE)) ? 17'd0
                                                 : 17'(23'(rdsh_pkg::ONE) - tdev2);
        bdev     = 23'(q5_side.t - 22'(rdsh_pkg::ONE / 2)) << 1;
        if (q5_side.t <= 22'(rdsh_pkg::ONE / 2))
        begin
            bq = 17'd0;
        end
        else if (bdev >= 23'(rdsh_pkg::ONE))
        begin
            bq = 17'(rdsh_pkg::ONE);
        end
        else
        begin
            bq = 17'(bdev);
        end
        ramp_full[0] = 25'(q5_side.rq) * 25'd255;
        ramp_full[1] = 25'(gq) * 25'd255;
        ramp_full[2] = 25'(bq) * 25'd255;
    end

    // Stage L: 60/40 mix with the base color.
    logic        l_vld_reg;
    logic [7:0]  l_mix_reg [3];
    logic [14:0] l_k_reg;
    logic [24:0] mix_full [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mix_full[i] = (25'(k_ramp_reg[i]) * 25'd6 + 25'(k_base_reg[i]) * 25'd4)
                          * 25'd6554;
        end
    end

    // Stage M: brighten toward white.
    logic [22:0] lift [3];
    logic [7:0]  shade_ch [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lift[i]     = 23'(8'd255 - l_mix_reg[i]) * 23'(l_k_reg);
            shade_ch[i] = l_mix_reg[i] + 8'(lift[i] >> 16);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            g_vld_reg   <= 1'b0;
            h_vld_reg   <= 1'b0;
            i_vld_reg   <= 1'b0;
            j_vld_reg   <= 1'b0;
            k_vld_reg   <= 1'b0;
            l_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            e_vld_reg   <= q1_vld;
            f_vld_reg   <= q2_vld;
            g_vld_reg   <= s2_vld;
            h_vld_reg   <= s3_vld;
            i_vld_reg   <= h_vld_reg;
            j_vld_reg   <= q6_vld;
            k_vld_reg   <= q5_vld;
            l_vld_reg   <= k_vld_reg;
            out_vld_reg <= l_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_num_reg  <= (beta_num >= beta_lim) ? beta_lim - 50'd1 : beta_num;
            e_den_reg  <= light_eff;
            e_side_reg <= q1_side;

            f_num_reg  <= {q2_side.neg ? ratio_lo : ratio_hi, 16'd0};
            f_den_reg  <= q2_side.neg ? ratio_hi : ratio_lo;
            f_side_reg <= q2_side;

            g_num_reg  <= {s2_side.hole_dist - rs_reg, 16'd0};
            g_den_reg  <= s2_side.hole_dist;
            g_side_reg <= g_side_next;

            h_prod_reg <= 38'(s3_side.dop) * 38'(grav);
            h_side_reg <= s3_side;

            i_side_reg <= i_side_next;

            j_num_reg  <= {rs3, 16'd0};
            j_den_reg  <= dmax;
            j_side_reg <= j_side_next;

            for (int i = 0; i < 3; i++)
            begin
                k_ramp_reg[i] <= ramp_full[i][23:16];
                l_mix_reg[i]  <= mix_full[i][23:16];
            end
            k_base_reg[0] <= q5_side.base_red;
            k_base_reg[1] <= q5_side.base_green;
            k_base_reg[2] <= q5_side.base_blue;
            k_k_reg       <= k_scaled[32:18];
            l_k_reg       <= k_k_reg;

            out_reg.out_red   <= shade_ch[0];
            out_reg.out_green <= shade_ch[1];
            out_reg.out_blue  <= shade_ch[2];
        end
    end

endmodule

FILE: hw/rtl/rdsh_checker.sv
// Port checker of the shading block and its binding to the top level.
`include "redshift_doppler_shade_assert.svh"

module rdsh_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input rdsh_pkg::out_item_t out_data
);

    `RDS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "Stalled color changed or dropped")
    `RDS_ASSERT_ALWAYS(a_ready_when_empty, in_ready || out_valid, "Input refused with no color waiting")
    `RDS_ASSERT(a_ready_follows, out_ready |-> in_ready, "Input refused while the output drains")
    `RDS_ASSERT(a_no_accept_stall, in_valid && !in_ready |-> out_valid && !out_ready, "Input stalled without an output stall")

endmodule

bind redshift_doppler_shade rdsh_checker u_rdsh_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(particle.valid),
    .in_ready(particle.ready),
    .out_valid(shade.valid),
    .out_ready(shade.ready),
    .out_data(shade.data)
);

FILE: sim/tb.sv
// Self-checking testbench of the Doppler and gravitational particle shading block.
module tb;

    localparam longint ONE_Q = longint'(rdsh_pkg::ONE);

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    rdsh_in_if  particle ();
    rdsh_out_if shade ();

    redshift_doppler_shade dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .particle  (particle),
        .shade     (shade)
    );

    always #4 clk = ~clk;

    longint              cam_pos [3];
    longint              radius_q;
    longint              light_q;
    rdsh_pkg::out_item_t pending_shades [$];
    int unsigned         error_count = 0;
    bit                  calm = 1'b0;
    bit                  hold_shade = 1'b0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic rdsh_pkg::out_item_t shade_of(rdsh_pkg::in_item_t p);
        longint              e [3];
        longint              vel [3];
        longint unsigned     base [3];
        longint unsigned     ramp [3];
        longint              beta, rs, hdist, len, dot, c, speed, ratio, t, rq, gq, bq, mx, k;
        longint unsigned     sum, dop, grav, q, mix, o;
        bit                  scaled, big;
        rdsh_pkg::out_item_t r;
        beta = 0;
        sum = 0;
        scaled = 1'b0;
        rs = radius_q;
        hdist = longint'(p.hole_distance);
        base[0] = p.base_red;
        base[1] = p.base_green;
        base[2] = p.base_blue;
        vel[0] = longint'($signed(p.vel_x));
        vel[1] = longint'($signed(p.vel_y));
        vel[2] = longint'($signed(p.vel_z));
        e[0] = cam_pos[0] - longint'($signed(p.pos_x));
        e[1] = cam_pos[1] - longint'($signed(p.pos_y));
        e[2] = cam_pos[2] - longint'($signed(p.pos_z));
        do
        begin
            big = 1'b0;
            for (int i = 0; i < 3; i++)
                if (e[i] >= (64'sd1 <<< 30) || e[i] <= -(64'sd1 <<< 30))
                    big = 1'b1;
            if (big)
            begin
                for (int i = 0; i < 3; i++)
                    e[i] = e[i] / 2;
                scaled = 1'b1;
            end
        end while (big);
        for (int i = 0; i < 3; i++)
            sum = sum + longint'(e[i] * e[i]);
        if (scaled || sum > longint'(rdsh_pkg::THR_SQ))
        begin
            len = longint'(int_sqrt(sum));
            dot = vel[0] * e[0] + vel[1] * e[1] + vel[2] * e[2];
            c = (light_q != 0) ? light_q : 1;
            if (len < 1)
                len = 1;
            speed = dot / len;
            beta = speed * ONE_Q / c;
            if (beta > rdsh_pkg::B999)
                beta = rdsh_pkg::B999;
            if (beta < -rdsh_pkg::B999)
                beta = -rdsh_pkg::B999;
        end
        ratio = (ONE_Q + beta) * ONE_Q / (ONE_Q - beta);
        dop = int_sqrt(longint'(ratio) << rdsh_pkg::FRAC);
        grav = 0;
        if (hdist * 100 > rs * 101)
        begin
            q = (hdist - rs) * ONE_Q / hdist;
            grav = int_sqrt(q << rdsh_pkg::FRAC);
        end
        t = longint'((dop * grav) >> rdsh_pkg::FRAC);
        if (t < rdsh_pkg::T_MIN)
            t = rdsh_pkg::T_MIN;
        rq = 2 * ONE_Q * ONE_Q / t;
        if (rq > ONE_Q)
            rq = ONE_Q;
        gq = t - ONE_Q;
        if (gq < 0)
            gq = -gq;
        gq = ONE_Q - 2 * gq;
        if (gq < 0)
            gq = 0;
        bq = 2 * (t - ONE_Q / 2);
        if (bq < 0)
            bq = 0;
        if (bq > ONE_Q)
            bq = ONE_Q;
        ramp[0] = longint'(rq * 255) >> rdsh_pkg::FRAC;
        ramp[1] = longint'(gq * 255) >> rdsh_pkg::FRAC;
        ramp[2] = longint'(bq * 255) >> rdsh_pkg::FRAC;
        mx = (rs > hdist) ? rs : hdist;
        if (mx == 0)
            k = ONE_Q;
        else
        begin
            k = 3 * rs * ONE_Q / mx;
            if (k > ONE_Q)
                k = ONE_Q;
        end
        k = 2 * k / 5;
        for (int i = 0; i < 3; i++)
        begin
            mix = (6 * ramp[i] + 4 * base[i]) / 10;
            o = mix + (((255 - mix) * longint'(k)) >> rdsh_pkg::FRAC);
            case (i)
                0: r.out_red = o[7:0];
                1: r.out_green = o[7:0];
                default: r.out_blue = o[7:0];
            endcase
        end
        return r;
    endfunction

    always @(negedge clk)
        shade.ready <= !hold_shade && (calm || $urandom_range(0, 99) >= 11);

    always @(posedge clk)
    begin
        rdsh_pkg::out_item_t want;
        if (rst_n && shade.valid && shade.ready)
        begin
            if (pending_shades.size() == 0)
            begin
                $display("%0t: unexpected color %h", $time, shade.data);
                error_count++;
            end
            else
            begin
                want = pending_shades.pop_front();
                if (shade.data.out_red !== want.out_red)
                begin
                    $display("%0t: red expected %0d actual %0d", $time,
                             want.out_red, shade.data.out_red);
                    error_count++;
                end
                if (shade.data.out_green !== want.out_green)
                begin
                    $display("%0t: green expected %0d actual %0d", $time,
                             want.out_green, shade.data.out_green);
                    error_count++;
                end
                if (shade.data.out_blue !== want.out_blue)
                begin
                    $display("%0t: blue expected %0d actual %0d", $time,
                             want.out_blue, shade.data.out_blue);
                    error_count++;
                end
            end
        end
    end

    task automatic send_particle(rdsh_pkg::in_item_t p);
        while (!calm && $urandom_range(0, 99) < 11)
            @(negedge clk);
        particle.valid = 1'b1;
        particle.data = p;
        do
            @(posedge clk);
        while (!particle.ready);
        pending_shades.push_back(shade_of(p));
        @(negedge clk);
        particle.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_shades.size() != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
    endtask

    task automatic write_reg(rdsh_pkg::cfg_index_t idx, logic [31:0] value);
        wait_drained();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            rdsh_pkg::CFG_CAMERA_X: cam_pos[0] = longint'($signed(value));
            rdsh_pkg::CFG_CAMERA_Y: cam_pos[1] = longint'($signed(value));
            rdsh_pkg::CFG_CAMERA_Z: cam_pos[2] = longint'($signed(value));
            rdsh_pkg::CFG_HORIZON_RADIUS: radius_q = longint'(value[30:0]);
            default: light_q = longint'(value[30:0]);
        endcase
    endtask

    function automatic logic [31:0] pick_word(longint center);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'(center + $signed($urandom_range(0, 400)) - 200);
            2: return 32'(center + $signed($urandom_range(0, 1 << 22)) - (1 << 21));
            default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    function automatic rdsh_pkg::in_item_t random_particle();
        rdsh_pkg::in_item_t p;
        logic [31:0] w;
        p.base_red = $urandom;
        p.base_green = $urandom;
        p.base_blue = $urandom;
        p.vel_x = pick_word(0);
        p.vel_y = pick_word(0);
        p.vel_z = pick_word(0);
        p.pos_x = pick_word(cam_pos[0]);
        p.pos_y = pick_word(cam_pos[1]);
        p.pos_z = pick_word(cam_pos[2]);
        case ($urandom_range(0, 4))
            0: w = $urandom;
            1: w = 32'(radius_q + $urandom_range(0, 64) - 32);
            2: w = 32'(radius_q * $urandom_range(1, 8));
            3: w = $urandom_range(0, 3);
            default: w = $urandom_range(0, 1 << 22);
        endcase
        p.hole_distance = w[30:0];
        return p;
    endfunction

    task automatic test_directed();
        rdsh_pkg::in_item_t p;
        p = '0;
        p.pos_y = 32'(cam_pos[1]);
        send_particle(p);
        p = '1;
        send_particle(p);
        p.vel_x = 32'sh7fffffff;
        p.vel_y = 32'sh80000000;
        p.vel_z = 32'sh7fffffff;
        p.pos_x = 32'sh80000000;
        p.pos_y = 32'sh7fffffff;
        p.pos_z = 32'sh80000000;
        p.hole_distance = '1;
        send_particle(p);
        p.vel_x = 32'sh80000000;
        p.vel_y = 32'sh7fffffff;
        p.base_red = 8'd0;
        p.hole_distance = 31'd65536;
        send_particle(p);
        p.vel_x = 0;
        p.vel_y = 32'sh00100000;
        p.vel_z = 0;
        p.pos_x = 0;
        p.pos_y = 0;
        p.pos_z = 0;
        p.hole_distance = 31'd66191;
        send_particle(p);
        p.hole_distance = 31'd66192;
        send_particle(p);
        p.vel_y = -32'sh00100000;
        p.hole_distance = 31'd10 << 16;
        send_particle(p);
        p.hole_distance = 0;
        send_particle(p);
        p.pos_y = 32'(cam_pos[1] - 66);
        p.vel_y = 32'sh00010000;
        send_particle(p);
        p.pos_y = 32'(cam_pos[1] - 67);
        send_particle(p);
        repeat (8)
            send_particle(random_particle());
    endtask

    task automatic run_phase(int n);
        repeat (n)
            send_particle(random_particle());
    endtask

    task automatic test_config_sweep();
        rdsh_pkg::in_item_t p;
        write_reg(rdsh_pkg::CFG_CAMERA_X, 32'h7fffffff);
        write_reg(rdsh_pkg::CFG_CAMERA_Y, 32'h80000000);
        write_reg(rdsh_pkg::CFG_CAMERA_Z, 32'h7fffffff);
        write_reg(rdsh_pkg::CFG_LIGHT_SPEED, 32'h7fffffff);
        write_reg(rdsh_pkg::CFG_HORIZON_RADIUS, 32'h7fffffff);
        run_phase(60);
        write_reg(rdsh_pkg::CFG_CAMERA_X, 32'h80000000);
        write_reg(rdsh_pkg::CFG_CAMERA_Z, 32'h80000000);
        write_reg(rdsh_pkg::CFG_LIGHT_SPEED, 32'h0);
        write_reg(rdsh_pkg::CFG_HORIZON_RADIUS, 32'h0);
        p = random_particle();
        p.hole_distance = 0;
        send_particle(p);
        run_phase(60);
        write_reg(rdsh_pkg::CFG_LIGHT_SPEED, 32'h1);
        write_reg(rdsh_pkg::CFG_HORIZON_RADIUS, 32'h1);
        write_reg(rdsh_pkg::CFG_CAMERA_Y, 32'h7fffffff);
        run_phase(60);
        write_reg(rdsh_pkg::CFG_CAMERA_X, $urandom);
        write_reg(rdsh_pkg::CFG_CAMERA_Y, $urandom_range(0, 1 << 24));
        write_reg(rdsh_pkg::CFG_CAMERA_Z, $urandom);
        write_reg(rdsh_pkg::CFG_LIGHT_SPEED, 32'h00400000);
        write_reg(rdsh_pkg::CFG_HORIZON_RADIUS, 32'h00080000);
        run_phase(60);
        write_reg(rdsh_pkg::CFG_CAMERA_X, 0);
        write_reg(rdsh_pkg::CFG_CAMERA_Y, 32'd19660800);
        write_reg(rdsh_pkg::CFG_CAMERA_Z, 0);
        write_reg(rdsh_pkg::CFG_LIGHT_SPEED, 32'd65536);
        write_reg(rdsh_pkg::CFG_HORIZON_RADIUS, 32'd65536);
    endtask

    task automatic test_backpressure();
        hold_shade = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_shade = 1'b0;
            end
            run_phase(300);
        join
    endtask

    task automatic test_random();
        calm = 1'b1;
        run_phase(60);
        calm = 1'b0;
        run_phase(190);
    endtask

    initial
    begin
        cam_pos[0] = 0;
        cam_pos[1] = 19660800;
        cam_pos[2] = 0;
        radius_q = 65536;
        light_q = 65536;
        particle.valid = 1'b0;
        particle.data = '0;
        shade.ready = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_config_sweep();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (230) @(negedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/rdsh_pkg.sv
hw/rtl/rdsh_in_if.sv
hw/rtl/rdsh_out_if.sv
hw/rtl/rdsh_div.sv
hw/rtl/rdsh_sqrt.sv
hw/rtl/redshift_doppler_shade.sv
hw/rtl/rdsh_checker.sv
sim/tb.sv
